[rtl/epoch_seconds_to_calendar_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar block
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

`ifndef ASSERT_OFF
`define ES2C_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("es2c assertion failed");
`define ES2C_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("es2c assertion failed");
`else
`define ES2C_ASSERT_IMP(label, ante, cons)
`define ES2C_ASSERT_NXT(label, ante, cons)
`endif

`endif

[rtl/es2c_pkg.sv]
// ----------------------------------------------------------------------------
// es2c_pkg
// Types, constants and the month length table shared by the calendar block.
// ----------------------------------------------------------------------------
package es2c_pkg;

    localparam int SEC_W       = 33;
    localparam int DAYS_W      = 16;
    localparam int YEAR_W      = 12;
    localparam int CNT_W       = 2;
    localparam int DIG_W       = 22;
    localparam int QDIG_W      = 16;
    localparam int RECIP_W     = 26;
    localparam int PROD_W      = 44;
    localparam int RECIP_SHIFT = 28;

    localparam logic [2:0] CFG_OFFSET_HOURS   = 3'd0;
    localparam logic [2:0] CFG_OFFSET_MINUTES = 3'd1;
    localparam logic [2:0] CFG_OFFSET_SECONDS = 3'd2;
    localparam logic [2:0] CFG_EPOCH_WEEKDAY  = 3'd3;
    localparam logic [2:0] CFG_EPOCH_YEAR     = 3'd4;

    localparam logic [5:0] SECS_PER_MIN  = 6'd60;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [5:0] DAYS_PER_WEEK = 6'd7;

    // Each reciprocal is 2^28 / d rounded up. It gives the exact quotient of
    // any 22-bit dividend by d.
    localparam logic [RECIP_W-1:0] RECIP_60 = 26'd4473925;
    localparam logic [RECIP_W-1:0] RECIP_24 = 26'd11184811;
    localparam logic [RECIP_W-1:0] RECIP_7  = 26'd38347923;

    localparam logic [DAYS_W-1:0] DAYS_COMMON = 16'd365;
    localparam logic [DAYS_W-1:0] DAYS_LEAP   = 16'd366;
    localparam logic [10:0] CENTURY_1    = 11'd100;
    localparam logic [10:0] CENTURY_2    = 11'd200;
    localparam logic [10:0] CENTURY_3    = 11'd300;
    localparam logic [10:0] CYCLE_LAST   = 11'd399;
    localparam logic [DAYS_W-1:0] CYCLE_YEARS = 16'd400;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    typedef struct packed {
        logic [4:0]  offset_hours;
        logic [5:0]  offset_minutes;
        logic [5:0]  offset_seconds;
        logic [2:0]  epoch_weekday;
        logic [10:0] epoch_year;
    } es2c_cfg_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [2:0]        weekday;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } es2c_result_t;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/es2c_core.sv]
// ----------------------------------------------------------------------------
// es2c_core
// Sequencer around one shared multiply and subtract unit: each time field is
// split off by a division by a constant, done on a 17-bit high digit and a
// 16-bit low digit with a reciprocal multiply and a remainder subtract each,
// then a year walk and a month walk over the day count.
// ----------------------------------------------------------------------------
module es2c_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            epoch_seconds,
    input  es2c_pkg::es2c_cfg_t    cfg,
    input  logic                   take,
    output logic                   busy,
    output logic                   done,
    output es2c_pkg::es2c_result_t result
);
    import es2c_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_YMOD  = 3'd2;
    localparam logic [2:0] ST_YEAR  = 3'd3;
    localparam logic [2:0] ST_MONTH = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [1:0] PH_SEC  = 2'd0;
    localparam logic [1:0] PH_MIN  = 2'd1;
    localparam logic [1:0] PH_HOUR = 2'd2;
    localparam logic [1:0] PH_WDAY = 2'd3;

    localparam logic [CNT_W-1:0] STEP_HI_MUL = 2'd0;
    localparam logic [CNT_W-1:0] STEP_HI_REM = 2'd1;
    localparam logic [CNT_W-1:0] STEP_LO_MUL = 2'd2;
    localparam logic [CNT_W-1:0] STEP_LO_REM = 2'd3;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [5:0]        rem_reg, rem_next;
    logic [SEC_W-1:0]  num_reg, num_next;
    logic [QDIG_W-1:0] qd_reg, qd_next;
    logic [QDIG_W-1:0] qhi_reg, qhi_next;
    logic [5:0]        sec_reg, sec_next;
    logic [5:0]        min_reg, min_next;
    logic [4:0]        hour_reg, hour_next;
    logic [2:0]        wday_reg, wday_next;
    logic [DAYS_W-1:0] days_reg, days_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [10:0]       ymod_reg, ymod_next;
    logic [3:0]        month_reg, month_next;

    logic [5:0]         divisor;
    logic [RECIP_W-1:0] recip;
    logic               lo_digit;
    logic [DIG_W-1:0]   dig;
    logic [PROD_W-1:0]  prod;
    logic [DIG_W-1:0]   qd_times_d;
    logic [SEC_W-1:0]   quotient;
    logic               leap;
    logic [DAYS_W-1:0]  ylen;
    logic [4:0]         mlen;
    logic [DIG_W-1:0]   sub_a, sub_b, sub_diff;
    logic               sub_ge;
    logic [5:0]         rem_new;

    always_comb
    begin
        unique case (phase_reg)
            PH_SEC:
            begin
                divisor = SECS_PER_MIN;
                recip   = RECIP_60;
            end
            PH_MIN:
            begin
                divisor = MINS_PER_HOUR;
                recip   = RECIP_60;
            end
            PH_HOUR:
            begin
                divisor = HOURS_PER_DAY;
                recip   = RECIP_24;
            end
            PH_WDAY:
            begin
                divisor = DAYS_PER_WEEK;
                recip   = RECIP_7;
            end
            default:
            begin
                divisor = SECS_PER_MIN;
                recip   = RECIP_60;
            end
        endcase
    end

    // The low digit carries the remainder of the high digit above it, so both
    // digits fit in 22 bits.
    assign lo_digit   = (cnt_reg == STEP_LO_MUL) || (cnt_reg == STEP_LO_REM);
    assign dig        = lo_digit ? {rem_reg, num_reg[15:0]}
                                 : {5'd0, num_reg[SEC_W-1:16]};
    assign prod       = PROD_W'(dig) * PROD_W'(recip);
    assign qd_times_d = DIG_W'(qd_reg) * DIG_W'(divisor);
    assign quotient   = {1'b0, qhi_reg, qd_reg};

    assign leap = (year_reg[1:0] == 2'b00) &&
                  !(ymod_reg == CENTURY_1 || ymod_reg == CENTURY_2 || ymod_reg == CENTURY_3);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = month_length(month_reg, leap);

    always_comb
    begin
        unique case (state_reg)
            ST_DIV:
            begin
                sub_a = dig;
                sub_b = qd_times_d;
            end
            ST_YMOD:
            begin
                sub_a = {11'd0, ymod_reg};
                sub_b = {6'd0, CYCLE_YEARS};
            end
            ST_YEAR:
            begin
                sub_a = {6'd0, days_reg};
                sub_b = {6'd0, ylen};
            end
            ST_MONTH:
            begin
                sub_a = {6'd0, days_reg};
                sub_b = {17'd0, mlen};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_ge   = (sub_a >= sub_b);
    assign sub_diff = sub_a - sub_b;
    assign rem_new  = sub_diff[5:0];

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        qd_next    = qd_reg;
        qhi_next   = qhi_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        wday_next  = wday_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        month_next = month_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next   = {1'b0, epoch_seconds} + SEC_W'(cfg.offset_seconds);
                    rem_next   = '0;
                    cnt_next   = STEP_HI_MUL;
                    phase_next = PH_SEC;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                unique case (cnt_reg)
                    STEP_HI_MUL:
                    begin
                        qd_next  = prod[RECIP_SHIFT+QDIG_W-1:RECIP_SHIFT];
                        cnt_next = STEP_HI_REM;
                    end
                    STEP_HI_REM:
                    begin
                        qhi_next = qd_reg;
                        rem_next = rem_new;
                        cnt_next = STEP_LO_MUL;
                    end
                    STEP_LO_MUL:
                    begin
                        qd_next  = prod[RECIP_SHIFT+QDIG_W-1:RECIP_SHIFT];
                        cnt_next = STEP_LO_REM;
                    end
                    STEP_LO_REM:
                    begin
                        cnt_next = STEP_HI_MUL;
                        rem_next = '0;
                        unique case (phase_reg)
                            PH_SEC:
                            begin
                                sec_next   = rem_new;
                                num_next   = quotient + SEC_W'(cfg.offset_minutes);
                                phase_next = PH_MIN;
                            end
                            PH_MIN:
                            begin
                                min_next   = rem_new;
                                num_next   = quotient + SEC_W'(cfg.offset_hours);
                                phase_next = PH_HOUR;
                            end
                            PH_HOUR:
                            begin
                                hour_next  = rem_new[4:0];
                                days_next  = quotient[DAYS_W-1:0];
                                num_next   = quotient + SEC_W'(cfg.epoch_weekday);
                                phase_next = PH_WDAY;
                            end
                            PH_WDAY:
                            begin
                                wday_next  = rem_new[2:0];
                                ymod_next  = cfg.epoch_year;
                                year_next  = {1'b0, cfg.epoch_year};
                                state_next = ST_YMOD;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                    default:
                    begin
                        cnt_next = STEP_HI_MUL;
                    end
                endcase
            end
            ST_YMOD:
            begin
                if (sub_ge)
                begin
                    ymod_next = sub_diff[10:0];
                end
                else
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (sub_ge)
                begin
                    days_next = sub_diff[DAYS_W-1:0];
                    year_next = year_reg + 1'b1;
                    ymod_next = (ymod_reg == CYCLE_LAST) ? 11'd0 : ymod_reg + 1'b1;
                end
                else
                begin
                    month_next = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (sub_ge && month_reg != MONTH_DEC)
                begin
                    days_next  = sub_diff[DAYS_W-1:0];
                    month_next = month_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SEC;
            cnt_reg   <= STEP_HI_MUL;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        qd_reg    <= qd_next;
        qhi_reg   <= qhi_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
        wday_reg  <= wday_next;
        days_reg  <= days_next;
        year_reg  <= year_next;
        ymod_reg  <= ymod_next;
        month_reg <= month_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign result.year    = year_reg;
    assign result.month   = month_reg + 1'b1;
    assign result.day     = days_reg[4:0] + 1'b1;
    assign result.weekday = wday_reg;
    assign result.hour    = hour_reg;
    assign result.minute  = min_reg;
    assign result.second  = sec_reg;

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since the epoch into a local Gregorian date and time.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, epoch_seconds) takes one beat at a
// time; in_stall is high from the cycle after a beat is taken until the
// conversion has moved into the output register. The output channel
// (out_valid, out_stall and the result fields) presents one beat per input.
// One shared multiply and subtract unit does all the work: four divisions by
// 60, 60, 24 and 7, each a multiply and a remainder subtract on the high
// digit and then on the low digit; a reduction of the epoch year modulo 400;
// a walk over the elapsed years; a walk over the months; and the hand-over
// of the result. The next input beat is taken only after the result has
// moved on, so one conversion runs at a time.
// A finished result waits in the output register while the next beat is
// taken; if the receiver still stalls when that beat is done, the core holds
// it until the output register frees up. Reset clears both channels and
// loads the register defaults (offset 09:00:00, Thursday, year 1970). The
// configuration channel is always ready and should be written while idle.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [2:0]  weekday_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import es2c_pkg::*;

    es2c_cfg_t    cfg_reg;
    es2c_result_t core_result;
    es2c_result_t result_reg;
    logic         out_valid_reg;
    logic         core_busy;
    logic         core_done;
    logic         take;
    logic         start;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_hours   <= 5'd9;
            cfg_reg.offset_minutes <= 6'd0;
            cfg_reg.offset_seconds <= 6'd0;
            cfg_reg.epoch_weekday  <= 3'd4;
            cfg_reg.epoch_year     <= 11'd1970;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OFFSET_HOURS:   cfg_reg.offset_hours   <= cfg_data[4:0];
                CFG_OFFSET_MINUTES: cfg_reg.offset_minutes <= cfg_data[5:0];
                CFG_OFFSET_SECONDS: cfg_reg.offset_seconds <= cfg_data[5:0];
                CFG_EPOCH_WEEKDAY:  cfg_reg.epoch_weekday  <= cfg_data[2:0];
                CFG_EPOCH_YEAR:     cfg_reg.epoch_year     <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign in_stall = core_busy;
    assign start    = in_valid && !core_busy;
    assign take     = !out_valid_reg || !out_stall;

    es2c_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .epoch_seconds (epoch_seconds),
        .cfg           (cfg_reg),
        .take          (take),
        .busy          (core_busy),
        .done          (core_done),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_done && take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done && take)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign year_out    = result_reg.year;
    assign month_out   = result_reg.month;
    assign day_out     = result_reg.day;
    assign weekday_out = result_reg.weekday;
    assign hour_out    = result_reg.hour;
    assign minute_out  = result_reg.minute;
    assign second_out  = result_reg.second;

    `ES2C_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `ES2C_ASSERT_IMP(a_month_range, out_valid, month_out >= 4'd1 && month_out <= 4'd12)
    `ES2C_ASSERT_IMP(a_day_range, out_valid, day_out >= 5'd1 && weekday_out < 3'd7)
    `ES2C_ASSERT_IMP(a_hour_range, out_valid, hour_out < 5'd24)
    `ES2C_ASSERT_IMP(a_clock_range, out_valid, minute_out < 6'd60 && second_out < 6'd60)

endmodule

[tb/sv/tb_epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// Testbench for epoch_seconds_to_calendar
// Drives epoch second counts through the converter under several time-zone,
// weekday and epoch-year settings, with bursty input and a stalling receiver,
// and checks every calendar beat against an independent date calculation.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

    import es2c_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 4_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 3000;
    localparam int unsigned SETTLE_CYCLES   = 20;
    localparam int unsigned DRAIN_CYCLES    = 400;
    localparam int unsigned PHASE_ITEMS     = 165;

    class calendar_scoreboard;
        es2c_cfg_t    zone;
        es2c_result_t pending_dates[$];
        int unsigned  month_days[12];
        int unsigned  mismatches;
        int unsigned  dates_checked;

        function new();
            zone = '{offset_hours: 5'd9, offset_minutes: 6'd0, offset_seconds: 6'd0,
                     epoch_weekday: 3'd4, epoch_year: 11'd1970};
            month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            mismatches = 0;
            dates_checked = 0;
        endfunction

        function void apply_register(logic [2:0] index, logic [10:0] value);
            case (index)
                CFG_OFFSET_HOURS:   zone.offset_hours = value[4:0];
                CFG_OFFSET_MINUTES: zone.offset_minutes = value[5:0];
                CFG_OFFSET_SECONDS: zone.offset_seconds = value[5:0];
                CFG_EPOCH_WEEKDAY:  zone.epoch_weekday = value[2:0];
                CFG_EPOCH_YEAR:     zone.epoch_year = value;
                default: ;
            endcase
        endfunction

        function bit leap_year(int unsigned year);
            return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        endfunction

        function es2c_result_t to_calendar(logic [31:0] secs);
            longint unsigned total;
            int unsigned     days;
            int unsigned     year;
            int unsigned     month;
            int unsigned     span;
            es2c_result_t    date;
            total = 64'(secs) + 64'(zone.offset_seconds);
            date.second = 6'(total % 60);
            total = total / 60 + 64'(zone.offset_minutes);
            date.minute = 6'(total % 60);
            total = total / 60 + 64'(zone.offset_hours);
            date.hour = 5'(total % 24);
            days = int'(total / 24);
            date.weekday = 3'((days + zone.epoch_weekday) % 7);
            year = zone.epoch_year;
            span = leap_year(year) ? 366 : 365;
            while (days >= span) begin
                days -= span;
                year++;
                span = leap_year(year) ? 366 : 365;
            end
            month = 0;
            span = month_days[0];
            while (days >= span && month != 11) begin
                days -= span;
                month++;
                span = (month == 1 && leap_year(year)) ? 29 : month_days[month];
            end
            date.year = 12'(year);
            date.month = 4'(month + 1);
            date.day = 5'(days + 1);
            return date;
        endfunction

        function void note_seconds(logic [31:0] secs);
            pending_dates.push_back(to_calendar(secs));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_date(es2c_result_t got);
            es2c_result_t want;
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = pending_dates.pop_front();
            dates_checked++;
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day", want.day, got.day);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("second", want.second, got.second);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] epoch_seconds = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    calendar_scoreboard sb = new();
    bit                 hold_off_request = 1'b0;
    int unsigned        cycle_count = 0;

    logic [31:0] calendar_corners [12] = '{
        32'd0, 32'd1, 32'd59, 32'd86399, 32'd31535999, 32'd951782400,
        32'd946684799, 32'h7FFF_FFFF, 32'd4107542399, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    epoch_seconds_to_calendar i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .epoch_seconds(epoch_seconds),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .year_out     (year_out),
        .month_out    (month_out),
        .day_out      (day_out),
        .weekday_out  (weekday_out),
        .hour_out     (hour_out),
        .minute_out   (minute_out),
        .second_out   (second_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_date({year_out, month_out, day_out, weekday_out,
                           hour_out, minute_out, second_out});
        end
    end

    task automatic offer_beat(input logic [31:0] secs);
        in_valid <= 1'b1;
        epoch_seconds <= secs;
        do @(posedge clk); while (in_stall);
        sb.note_seconds(secs);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_register(index, value);
    endtask

    // Unused upper data bits are randomized so that register masking is exercised.
    task automatic configure_zone(input logic [4:0] hours, input logic [5:0] minutes,
                                  input logic [5:0] seconds, input logic [2:0] weekday,
                                  input logic [10:0] year);
        while (sb.pending_dates.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_OFFSET_HOURS, {6'($urandom), hours});
        write_register(CFG_OFFSET_MINUTES, {5'($urandom), minutes});
        write_register(CFG_OFFSET_SECONDS, {5'($urandom), seconds});
        write_register(CFG_EPOCH_WEEKDAY, {8'($urandom), weekday});
        write_register(CFG_EPOCH_YEAR, year);
        write_register(3'($urandom_range(7, CFG_EPOCH_YEAR + 1)), 11'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_items(input int unsigned count);
        int unsigned burst_left;
        int unsigned gap;
        logic [31:0] secs;
        burst_left = 0;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                else if ($urandom_range(0, 7) == 0)
                    gap = $urandom_range(100, 400);
                else
                    gap = $urandom_range(1, 30);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
            end
            case ($urandom_range(0, 4))
                0: secs = 32'(longint'($urandom_range(0, 49710)) * 86400
                              + $urandom_range(0, 7200) - 3600);
                1: secs = $urandom_range(0, 200000);
                2: secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
                default: secs = $urandom;
            endcase
            offer_beat(secs);
            burst_left--;
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned stall_mode;
        int unsigned span;
        bit          held_off;
        held_off = 1'b0;
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            span = $urandom_range(20, 400);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_off_request && !held_off)
                begin
                    held_off = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (calendar_corners[i])
            offer_beat(calendar_corners[i]);
        run_items(PHASE_ITEMS);

        configure_zone(5'd31, 6'd63, 6'd63, 3'd7, 11'd2047);
        offer_beat(32'd0);
        offer_beat(32'hFFFF_FFFF);
        offer_beat(32'h8000_0000);
        run_items(PHASE_ITEMS);

        // Year zero is a leap year, so day 59 lands on February 29th.
        configure_zone(5'd0, 6'd0, 6'd0, 3'd0, 11'd0);
        offer_beat(32'd0);
        offer_beat(32'd5097600);
        offer_beat(32'hFFFF_FFFF);
        hold_off_request = 1'b1;
        run_items(PHASE_ITEMS);

        configure_zone(5'd23, 6'd59, 6'd59, 3'd6, 11'd1900);
        run_items(PHASE_ITEMS);

        configure_zone(5'd0, 6'd0, 6'd0, 3'd4, 11'd1970);
        run_items(PHASE_ITEMS);

        repeat (4)
        begin
            configure_zone(5'($urandom), 6'($urandom), 6'($urandom), 3'($urandom),
                           ($urandom_range(0, 1) == 0) ? 11'd1970 : 11'($urandom));
            run_items(PHASE_ITEMS);
        end

        while (sb.pending_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_dates.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[epoch_seconds_to_calendar.f]
+incdir+rtl
rtl/es2c_pkg.sv
rtl/es2c_core.sv
rtl/epoch_seconds_to_calendar.sv
tb/sv/tb_epoch_seconds_to_calendar.sv
